// ===== design/rtu_pkg.sv =====
// rtu_pkg: shared types, codes and constants of the trap unit
// no dependencies; imported by every module of the block

package rtu_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_ADDR_BITS = 6;
    localparam int CFG_SEL_BITS  = 3;
    localparam int CAUSE_BITS    = 6;
    localparam int IRQ_COUNT     = 12;
    localparam int STATUS_BITS   = 13;
    localparam int VEC_STRIDE    = 4;

    // status bit positions
    localparam int ST_SIE  = 1;
    localparam int ST_MIE  = 3;
    localparam int ST_SPIE = 5;
    localparam int ST_MPIE = 7;
    localparam int ST_SPP  = 8;
    localparam int ST_MPP  = 11;

    // pending bit positions driven by the interrupt lines
    localparam int IP_MSIP = 3;
    localparam int IP_MTIP = 7;
    localparam int IP_SEIP = 9;
    localparam int IP_MEIP = 11;

    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    localparam logic [1:0] VEC_MODE_VECTORED = 2'd1;

    typedef enum logic [2:0] {
        OP_SET_IRQ   = 3'd0,
        OP_POST_TRAP = 3'd1,
        OP_CHECK     = 3'd2,
        OP_MRET      = 3'd3,
        OP_SRET      = 3'd4
    } op_t;

    typedef enum logic [CFG_SEL_BITS-1:0] {
        REG_IRQ_ENABLE   = 3'd0,
        REG_IRQ_DELEG    = 3'd1,
        REG_EXC_DELEG    = 3'd2,
        REG_MACHINE_VEC  = 3'd3,
        REG_SUPER_VEC    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [IRQ_COUNT-1:0]     irq_enable_mask;
        logic [IRQ_COUNT-1:0]     irq_delegation_mask;
        logic [CFG_DATA_BITS-1:0] exc_delegation_mask;
        logic [CFG_DATA_BITS-1:0] machine_vector;
        logic [CFG_DATA_BITS-1:0] super_vector;
    } cfg_t;

    typedef struct packed {
        op_t                   operation;
        logic                  ext_irq;
        logic                  timer_irq;
        logic                  soft_irq;
        logic [CAUSE_BITS-1:0] exc_cause;
    } item_ctl_t;

    typedef struct packed {
        logic                  trap_taken;
        logic                  was_interrupt;
        logic [CAUSE_BITS-1:0] served_cause;
        logic                  redirect;
        logic [1:0]            new_privilege;
        logic                  double_fault;
        logic                  bad_level;
    } res_flags_t;

endpackage

// ===== design/rtu_cfg_regs.sv =====
// rtu_cfg_regs: configuration registers behind the apb-style port
// depends on rtu_pkg

module rtu_cfg_regs import rtu_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_SEL_BITS-1:0]  reg_sel,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx_t'(reg_sel))
                REG_IRQ_ENABLE:  cfg_next.irq_enable_mask     = pwdata[IRQ_COUNT-1:0];
                REG_IRQ_DELEG:   cfg_next.irq_delegation_mask = pwdata[IRQ_COUNT-1:0];
                REG_EXC_DELEG:   cfg_next.exc_delegation_mask = pwdata;
                REG_MACHINE_VEC: cfg_next.machine_vector      = pwdata;
                REG_SUPER_VEC:   cfg_next.super_vector        = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(reg_sel))
            REG_IRQ_ENABLE:  prdata = CFG_DATA_BITS'(cfg_reg.irq_enable_mask);
            REG_IRQ_DELEG:   prdata = CFG_DATA_BITS'(cfg_reg.irq_delegation_mask);
            REG_EXC_DELEG:   prdata = cfg_reg.exc_delegation_mask;
            REG_MACHINE_VEC: prdata = cfg_reg.machine_vector;
            REG_SUPER_VEC:   prdata = cfg_reg.super_vector;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/rtu_trap_core.sv =====
// rtu_trap_core: hart trap state and the single-pass decision for one item
// depends on rtu_pkg; state advances when the top level moves an item on

module rtu_trap_core import rtu_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  item_ctl_t            item,
    input  logic [WORD_BITS-1:0] trap_value,
    input  logic [WORD_BITS-1:0] current_pc,
    input  cfg_t                 cfg,
    output res_flags_t           res,
    output logic [WORD_BITS-1:0] res_next_pc
);

    logic [STATUS_BITS-1:0] status_reg,  status_next;
    logic [IRQ_COUNT-1:0]   pending_reg, pending_next;
    logic [1:0]             priv_reg,    priv_next;
    logic [WORD_BITS-1:0]   mepc_reg,    mepc_next;
    logic [WORD_BITS-1:0]   sepc_reg,    sepc_next;
    logic [WORD_BITS-1:0]   mcause_reg,  mcause_next;
    logic [WORD_BITS-1:0]   scause_reg,  scause_next;
    logic [WORD_BITS-1:0]   mtval_reg,   mtval_next;
    logic [WORD_BITS-1:0]   stval_reg,   stval_next;
    logic                   sync_pending_reg, sync_pending_next;
    logic [CAUSE_BITS-1:0]  sync_cause_reg,   sync_cause_next;
    logic [WORD_BITS-1:0]   sync_tval_reg,    sync_tval_next;

    logic [IRQ_COUNT-1:0]   irq_ok;
    logic                   irq_found;
    logic [CAUSE_BITS-1:0]  irq_cause;

    logic                   serve_go;
    logic                   serve_intr;
    logic                   serve_super;
    logic [CAUSE_BITS-1:0]  serve_cause;
    logic [WORD_BITS-1:0]   serve_epc;
    logic [WORD_BITS-1:0]   serve_code;
    logic [WORD_BITS-1:0]   vec;
    logic [WORD_BITS-1:0]   vec_target;

    // delegated interrupts cannot be taken above supervisor
    always_comb begin
        for (int c = 0; c < IRQ_COUNT; c++) begin
            irq_ok[c] = pending_reg[c] && cfg.irq_enable_mask[c] &&
                        (!cfg.irq_delegation_mask[c] || (priv_reg <= PRIV_S));
        end
    end

    // highest numbered eligible cause wins
    always_comb begin
        irq_found = 1'b0;
        irq_cause = '0;
        for (int c = 0; c < IRQ_COUNT; c++) begin
            if (irq_ok[c]) begin
                irq_found = 1'b1;
                irq_cause = CAUSE_BITS'(c);
            end
        end
    end

    always_comb begin
        status_next       = status_reg;
        pending_next      = pending_reg;
        priv_next         = priv_reg;
        mepc_next         = mepc_reg;
        sepc_next         = sepc_reg;
        mcause_next       = mcause_reg;
        scause_next       = scause_reg;
        mtval_next        = mtval_reg;
        stval_next        = stval_reg;
        sync_pending_next = sync_pending_reg;
        sync_cause_next   = sync_cause_reg;
        sync_tval_next    = sync_tval_reg;

        serve_go    = 1'b0;
        serve_intr  = 1'b0;
        serve_super = 1'b0;
        serve_cause = '0;
        serve_epc   = current_pc;
        res         = '0;
        res_next_pc = '0;

        case (item.operation)
            OP_SET_IRQ: begin
                pending_next[IP_MEIP] = item.ext_irq;
                pending_next[IP_SEIP] = item.ext_irq;
                pending_next[IP_MTIP] = item.timer_irq;
                pending_next[IP_MSIP] = item.soft_irq;
            end
            OP_POST_TRAP: begin
                if (!sync_pending_reg) begin
                    sync_pending_next = 1'b1;
                    sync_cause_next   = item.exc_cause;
                    sync_tval_next    = trap_value;
                end else begin
                    res.double_fault = 1'b1;
                end
            end
            OP_CHECK: begin
                if (sync_pending_reg) begin
                    serve_go    = 1'b1;
                    serve_cause = sync_cause_reg;
                    serve_super = cfg.exc_delegation_mask[sync_cause_reg] &&
                                  (priv_reg <= PRIV_S);
                    serve_epc   = current_pc - WORD_BITS'(VEC_STRIDE);
                    sync_pending_next = 1'b0;
                    sync_cause_next   = '0;
                    sync_tval_next    = '0;
                end else if (status_reg[priv_reg] && irq_found) begin
                    serve_go    = 1'b1;
                    serve_intr  = 1'b1;
                    serve_cause = irq_cause;
                    serve_super = cfg.irq_delegation_mask[irq_cause[3:0]];
                end
            end
            OP_MRET: begin
                priv_next            = status_reg[ST_MPP +: 2];
                status_next[ST_MIE]  = status_reg[ST_MPIE];
                status_next[ST_MPIE] = 1'b0;
                res.redirect         = 1'b1;
                res_next_pc          = mepc_reg;
            end
            OP_SRET: begin
                priv_next            = {1'b0, status_reg[ST_SPP]};
                status_next[ST_SIE]  = status_reg[ST_SPIE];
                status_next[ST_SPIE] = 1'b0;
                res.redirect         = 1'b1;
                res_next_pc          = sepc_reg;
            end
            default: begin
                res.bad_level = 1'b1;
            end
        endcase

        // trap entry: direct base, or base plus 4 * cause for vectored interrupts
        vec = serve_super ? cfg.super_vector[WORD_BITS-1:0]
                          : cfg.machine_vector[WORD_BITS-1:0];
        vec_target = {vec[WORD_BITS-1:2], 2'b00};
        if ((vec[1:0] == VEC_MODE_VECTORED) && serve_intr) begin
            vec_target = vec_target + (WORD_BITS'(serve_cause) << 2);
        end
        serve_code = {serve_intr, {(WORD_BITS-CAUSE_BITS-1){1'b0}}, serve_cause};

        if (serve_go) begin
            if (serve_super) begin
                sepc_next            = serve_epc;
                status_next[ST_SPP]  = priv_reg[0];
                status_next[ST_SPIE] = status_reg[ST_SIE];
                status_next[ST_SIE]  = 1'b0;
                stval_next           = sync_tval_reg;
                scause_next          = serve_code;
                priv_next            = PRIV_S;
            end else begin
                mepc_next               = serve_epc;
                status_next[ST_MPP +: 2] = priv_reg;
                status_next[ST_MPIE]    = status_reg[ST_MIE];
                status_next[ST_MIE]     = 1'b0;
                mtval_next              = sync_tval_reg;
                mcause_next             = serve_code;
                priv_next               = PRIV_M;
            end
            res.trap_taken    = 1'b1;
            res.was_interrupt = serve_intr;
            res.served_cause  = serve_cause;
            res.redirect      = 1'b1;
            res_next_pc       = vec_target;
        end

        res.new_privilege = priv_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg       <= '0;
            pending_reg      <= '0;
            priv_reg         <= PRIV_M;
            mepc_reg         <= '0;
            sepc_reg         <= '0;
            mcause_reg       <= '0;
            scause_reg       <= '0;
            mtval_reg        <= '0;
            stval_reg        <= '0;
            sync_pending_reg <= 1'b0;
            sync_cause_reg   <= '0;
            sync_tval_reg    <= '0;
        end else if (fire) begin
            status_reg       <= status_next;
            pending_reg      <= pending_next;
            priv_reg         <= priv_next;
            mepc_reg         <= mepc_next;
            sepc_reg         <= sepc_next;
            mcause_reg       <= mcause_next;
            scause_reg       <= scause_next;
            mtval_reg        <= mtval_next;
            stval_reg        <= stval_next;
            sync_pending_reg <= sync_pending_next;
            sync_cause_reg   <= sync_cause_next;
            sync_tval_reg    <= sync_tval_next;
        end
    end

endmodule

// ===== design/riscv_trap_unit_top.sv =====
// riscv_trap_unit_top: an input transfer reaches the result on m_valid through the
// input register then result register with the decision logic between them
// throughput one item per cycle; the trap state updates as an item enters the result register
// a waiting result holds the next item in the input register and stalls input with both full
// reset: synchronous, active low; clears all trap state and configuration, privilege machine
// depends on rtu_pkg, rtu_cfg_regs, rtu_trap_core

module riscv_trap_unit_top import rtu_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic                     s_ext_irq,
    input  logic                     s_timer_irq,
    input  logic                     s_soft_irq,
    input  logic [CAUSE_BITS-1:0]    s_exc_cause,
    input  logic [WORD_BITS-1:0]     s_trap_value,
    input  logic [WORD_BITS-1:0]     s_current_pc,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_trap_taken,
    output logic                     m_was_interrupt,
    output logic [CAUSE_BITS-1:0]    m_served_cause,
    output logic                     m_redirect,
    output logic [WORD_BITS-1:0]     m_next_pc,
    output logic [1:0]               m_new_privilege,
    output logic                     m_double_fault,
    output logic                     m_bad_level,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    cfg_t       cfg;
    res_flags_t core_res;
    logic [WORD_BITS-1:0] core_next_pc;

    logic                 in_valid_reg,  in_valid_next;
    item_ctl_t            in_ctl_reg;
    logic [WORD_BITS-1:0] in_tval_reg;
    logic [WORD_BITS-1:0] in_pc_reg;

    logic                 out_valid_reg, out_valid_next;
    res_flags_t           out_res_reg;
    logic [WORD_BITS-1:0] out_pc_reg;

    logic advance;
    logic s_xfer;

    assign pready = 1'b1;

    rtu_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .reg_sel (paddr[CFG_ADDR_BITS-1:CFG_ADDR_BITS-CFG_SEL_BITS]),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    rtu_trap_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (advance),
        .item        (in_ctl_reg),
        .trap_value  (in_tval_reg),
        .current_pc  (in_pc_reg),
        .cfg         (cfg),
        .res         (core_res),
        .res_next_pc (core_next_pc)
    );

    // item moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_xfer) begin
            in_ctl_reg.operation  <= op_t'(s_operation);
            in_ctl_reg.ext_irq    <= s_ext_irq;
            in_ctl_reg.timer_irq  <= s_timer_irq;
            in_ctl_reg.soft_irq   <= s_soft_irq;
            in_ctl_reg.exc_cause  <= s_exc_cause;
            in_tval_reg           <= s_trap_value;
            in_pc_reg             <= s_current_pc;
        end
        if (advance) begin
            out_res_reg <= core_res;
            out_pc_reg  <= core_next_pc;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_trap_taken    = out_res_reg.trap_taken;
    assign m_was_interrupt = out_res_reg.was_interrupt;
    assign m_served_cause  = out_res_reg.served_cause;
    assign m_redirect      = out_res_reg.redirect;
    assign m_next_pc       = out_pc_reg;
    assign m_new_privilege = out_res_reg.new_privilege;
    assign m_double_fault  = out_res_reg.double_fault;
    assign m_bad_level     = out_res_reg.bad_level;

endmodule

// ===== design/rtu_checker.sv =====
// rtu_checker: port-level checks on the trap unit's result channel
// depends on rtu_pkg; bound to riscv_trap_unit_top at the end of this file

module rtu_checker import rtu_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_trap_taken,
    input logic                  m_was_interrupt,
    input logic                  m_redirect,
    input logic [WORD_BITS-1:0]  m_next_pc,
    input logic [1:0]            m_new_privilege,
    input logic                  m_bad_level
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_pc))
        else $error("result changed while stalled");

    // every served trap steers the pc
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_trap_taken |-> m_redirect && !m_bad_level)
        else $error("trap served without redirect");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_was_interrupt |-> m_trap_taken)
        else $error("interrupt flag without trap");

    // traps land in supervisor or machine mode only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_trap_taken |-> (m_new_privilege == PRIV_S) ||
                                    (m_new_privilege == PRIV_M))
        else $error("trap served into wrong privilege");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_level |-> !m_redirect && (m_next_pc == '0))
        else $error("unknown operation changed the pc");

endmodule

bind riscv_trap_unit_top rtu_checker #(
    .WORD_BITS (WORD_BITS)
) u_rtu_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_trap_taken    (m_trap_taken),
    .m_was_interrupt (m_was_interrupt),
    .m_redirect      (m_redirect),
    .m_next_pc       (m_next_pc),
    .m_new_privilege (m_new_privilege),
    .m_bad_level     (m_bad_level)
);
